@@ design/des_block_cipher_unit_defines.svh @@
// Assertion macros shared by the cipher unit.
`ifndef DES_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define DES_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define DES_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DES_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ design/des_pkg.sv @@
package des_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned SubW   = 48;
  localparam int unsigned Rounds = 16;

  typedef logic [27:0] half_key_t;
  typedef logic [SubW-1:0] subkey_t;

  typedef struct packed {
    logic        enc;
    logic [31:0] l;
    logic [31:0] r;
    half_key_t   c;
    half_key_t   d;
  } round_data_t;

  typedef logic [7:0] tab64_t [64];

  localparam tab64_t IpTab = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam tab64_t FpTab = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] ETab [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] PTab [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

  localparam logic [7:0] Pc1Tab [56] = '{
    57,49,41,33,25,17,9,1, 58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3, 60,52,44,36,
    63,55,47,39,31,23,15,7, 62,54,46,38,30,22,14,6,
    61,53,45,37,29,21,13,5, 28,20,12,4};

  localparam logic [7:0] Pc2Tab [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

  localparam logic [1:0] RotTab [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] SboxTab [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm64(input logic [63:0] v, input tab64_t tab);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(tab[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(Pc1Tab[i])];
    return r;
  endfunction

  function automatic subkey_t pc2(input half_key_t c, input half_key_t d);
    logic [55:0] cd;
    subkey_t     r;
    cd = {c, d};
    for (int i = 0; i < 48; i++) r[47-i] = cd[56 - int'(Pc2Tab[i])];
    return r;
  endfunction

  function automatic half_key_t rotl(input half_key_t v, input logic [1:0] s);
    half_key_t r;
    r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    return r;
  endfunction

  function automatic half_key_t rotr(input half_key_t v, input logic [1:0] s);
    half_key_t r;
    r = (s == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] h, input subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  six;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) x[47-i] = h[32 - int'(ETab[i])];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SboxTab[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(PTab[i])];
    return p;
  endfunction

endpackage

@@ design/des_round.sv @@
module des_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_in,
  input  des_pkg::round_data_t d_in,
  output logic                 vld_out,
  output des_pkg::round_data_t d_out
);
  import des_pkg::*;

  round_data_t dat_r, dat_nxt;
  logic        vld_r;
  half_key_t   c_e, d_e;
  subkey_t     sk;

  // Encryption rotates left before the round; decryption uses the key as is,
  // then rotates right afterwards.
  always_comb begin
    c_e = d_in.enc ? rotl(d_in.c, RotTab[RoundIdx]) : d_in.c;
    d_e = d_in.enc ? rotl(d_in.d, RotTab[RoundIdx]) : d_in.d;
    sk  = pc2(c_e, d_e);
    dat_nxt.enc = d_in.enc;
    dat_nxt.l   = d_in.r;
    dat_nxt.r   = d_in.l ^ feistel(d_in.r, sk);
    dat_nxt.c   = d_in.enc ? c_e : rotr(c_e, RotTab[Rounds-1-RoundIdx]);
    dat_nxt.d   = d_in.enc ? d_e : rotr(d_e, RotTab[Rounds-1-RoundIdx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = dat_r;
endmodule

@@ design/des_block_cipher_unit.sv @@
// DES block cipher unit.
// Write the 64-bit key on cfg_key_we/cfg_key while no beat is in flight.
// Input beats carry in_block_in and in_encrypt on an in_valid/in_ready
// handshake; result beats carry out_block_out on out_valid/out_ready.
// Each beat passes through sixteen registered Feistel rounds, one per stage,
// and the subkey for each round is derived in that stage from the rotated
// key halves that travel with the beat.
// Throughput is one beat per cycle when the output is not stalled.
// The whole pipeline advances together; when out_ready is low and the last
// stage holds a result, every stage freezes and in_ready drops, so nothing
// is lost or repeated.
// Reset clears all valid bits and sets the key to zero.
module des_block_cipher_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_key_we,
  input  logic [des_pkg::KeyW-1:0]    cfg_key,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [des_pkg::BlockW-1:0]  in_block_in,
  input  logic                        in_encrypt,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [des_pkg::BlockW-1:0]  out_block_out
);
  import des_pkg::*;
  `include "des_block_cipher_unit_defines.svh"

  logic [KeyW-1:0] key_r;
  logic [55:0]     cd0;
  logic [63:0]     ipv;
  logic            adv;
  round_data_t     st_d [Rounds+1];
  logic            st_v [Rounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_key_we) begin
      key_r <= cfg_key;
    end
  end

  assign adv      = out_ready || !st_v[Rounds];
  assign in_ready = adv;

  always_comb begin
    cd0 = pc1(key_r);
    ipv = perm64(in_block_in, IpTab);
  end

  assign st_v[0] = in_valid;
  assign st_d[0] = {in_encrypt, ipv[63:32], ipv[31:0], cd0[55:28], cd0[27:0]};

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    des_round #(.RoundIdx(g)) u_rnd (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .vld_in (st_v[g]),
      .d_in   (st_d[g]),
      .vld_out(st_v[g+1]),
      .d_out  (st_d[g+1])
    );
  end

  assign out_valid     = st_v[Rounds];
  assign out_block_out = perm64({st_d[Rounds].r, st_d[Rounds].l}, FpTab);

  `DES_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_block_out))
  `DES_ASSERT_IMPL(a_ready, in_ready, out_ready || !out_valid)
  `DES_ASSERT_NEXT(a_flow, in_valid && in_ready, st_v[1])
endmodule

@@ dv/des_block_cipher_unit_test.sv @@
module des_block_cipher_unit_test;
  import des_pkg::*;

  typedef struct {
    logic [63:0] blk;
    logic        enc;
  } cipher_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_key_we = 1'b0;
  logic [63:0] cfg_key = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_in = '0;
  logic        in_encrypt = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_block_out;

  cipher_item_t block_queue[$];
  logic [63:0]  cipher_expected[$];
  logic [63:0]  key_shadow = '0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;
  int           out_beats = 0;
  int           hold_cycles = 0;
  bit           hold_done = 1'b0;
  int           enc_beats = 0;
  int           dec_beats = 0;
  int           key_writes = 0;

  des_block_cipher_unit u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_key_we(cfg_key_we), .cfg_key(cfg_key),
    .in_valid(in_valid), .in_ready(in_ready), .in_block_in(in_block_in),
    .in_encrypt(in_encrypt), .out_valid(out_valid), .out_ready(out_ready),
    .out_block_out(out_block_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] round_mix(input logic [31:0] h, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) x[47-i] = h[32 - int'(ETab[i])];
    x = x ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = SboxTab[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(PTab[i])];
    return p;
  endfunction

  function automatic logic [63:0] des_cipher(input logic [63:0] k, input logic [63:0] blk,
                                             input logic enc);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] subs[16];
    logic [63:0] v;
    logic [63:0] res;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 56; i++) cd[55-i] = k[64 - int'(Pc1Tab[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int n = 0; n < 16; n++) begin
      for (int j = 0; j < int'(RotTab[n]); j++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) subs[n][47-i] = cd[56 - int'(Pc2Tab[i])];
    end
    for (int i = 0; i < 64; i++) v[63-i] = blk[64 - int'(IpTab[i])];
    l = v[63:32];
    r = v[31:0];
    for (int n = 0; n < 16; n++) begin
      t = l ^ round_mix(r, enc ? subs[n] : subs[15-n]);
      l = r;
      r = t;
    end
    v = {r, l};
    for (int i = 0; i < 64; i++) res[63-i] = v[64 - int'(FpTab[i])];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cipher_expected.push_back(des_cipher(key_shadow, in_block_in, in_encrypt));
        if (in_encrypt) enc_beats++;
        else dec_beats++;
      end
      if (!in_valid || in_ready) begin
        if (block_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_block_in <= block_queue[0].blk;
          in_encrypt <= block_queue[0].enc;
          void'(block_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_beats++;
      if (cipher_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", out_block_out);
      end else begin
        if (out_block_out !== cipher_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, actual %h", cipher_expected[0], out_block_out);
        end
        void'(cipher_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (!hold_done && out_beats >= 400) begin
      hold_done = 1'b1;
      hold_cycles = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_key(input logic [63:0] k);
    @(posedge clk);
    cfg_key_we <= 1'b1;
    cfg_key <= k;
    @(posedge clk);
    cfg_key_we <= 1'b0;
    key_shadow = k;
    key_writes++;
  endtask

  task automatic add_block(input logic [63:0] blk, input logic enc);
    cipher_item_t it;
    it.blk = blk;
    it.enc = enc;
    block_queue.push_back(it);
  endtask

  task automatic drain_pipeline();
    do @(negedge clk);
    while (!(block_queue.size() == 0 && !in_valid && cipher_expected.size() == 0));
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [63:0] k;
    logic [63:0] b;
    if (des_cipher(64'h133457799BBCDFF1, 64'h0123456789ABCDEF, 1'b1) !== 64'h85E813540F0AB405)
      $display("Known-answer check of the predictor disagrees");
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add_block(64'h0, 1'b1);
    add_block('1, 1'b0);
    drain_pipeline();

    write_key(64'h133457799BBCDFF1);
    add_block(64'h0123456789ABCDEF, 1'b1);
    add_block(64'h85E813540F0AB405, 1'b0);
    add_block(64'h0, 1'b1);
    add_block(64'h0, 1'b0);
    add_block('1, 1'b1);
    add_block('1, 1'b0);
    add_block(64'hAAAAAAAAAAAAAAAA, 1'b1);
    add_block(64'h5555555555555555, 1'b0);
    add_block(64'h8000000000000000, 1'b1);
    add_block(64'h0000000000000001, 1'b0);
    drain_pipeline();

    write_key('1);
    add_block(64'h0, 1'b1);
    add_block('1, 1'b0);
    drain_pipeline();
    write_key(64'h0101010101010101);
    add_block(64'h0123456789ABCDEF, 1'b1);
    add_block(64'h0123456789ABCDEF, 1'b0);
    drain_pipeline();
    write_key(64'h01FE01FE01FE01FE);
    add_block(64'h0123456789ABCDEF, 1'b1);
    add_block(64'hFEDCBA9876543210, 1'b0);
    drain_pipeline();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 4) k = '1;
      else if (ph == 5) k = 64'h0;
      else k = {$urandom(), $urandom()};
      write_key(k);
      for (int n = 0; n < 124; n++) begin
        b = {$urandom(), $urandom()};
        add_block(b, 1'($urandom_range(1)));
        if ($urandom_range(9) == 0) add_block(des_cipher(k, b, 1'b1), 1'b0);
      end
      drain_pipeline();
    end

    $display("Covered %0d encrypt and %0d decrypt beats under %0d key settings,",
             enc_beats, dec_beats, key_writes);
    $display("with idle and stall mixes and one long output hold-off.");
    if (mismatches == 0 && cipher_expected.size() == 0) begin
      $display("des_block_cipher_unit test passed");
    end else begin
      $display("des_block_cipher_unit test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("des_block_cipher_unit test failed");
    $finish;
  end

endmodule
